@@ rtl/serial_command_line_parser_defines.svh @@
// Assertion macros used by the parser datapath RTL.
`ifndef SERIAL_COMMAND_LINE_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_LINE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Check at every clock edge outside reset.
`define SCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scp check failed");
// Check at every clock edge, reset included.
`define SCP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scp check failed");
`else
`define SCP_ASSERT(lbl, prop)
`define SCP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/scp_pkg.sv @@
`default_nettype none

package scp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_H     = 8'h48;

  localparam logic [15:0] PERIOD_MIN = 16'd10;
  localparam logic [15:0] PERIOD_MAX = 16'd10000;
  localparam logic [7:0]  SIM_MIN    = 8'd50;
  localparam logic [13:0] PERIOD_RESET = 14'd10;
  localparam logic [7:0]  SIM_RESET    = 8'd50;
  localparam logic [2:0]  HELP_LAST    = 3'd4;

  typedef enum logic [2:0] {
    OP_FLASH, OP_BLANK, OP_INTERVAL, OP_SIM, OP_PATTERN, OP_HELP, OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    ERR_MODE, ERR_COMMAND, ERR_DELIM, ERR_VALUE, ERR_LIMIT, ERR_INDEX, ERR_COMMA
  } err_t;

  typedef enum logic [3:0] {
    SRC_RX, SRC_ERR, SRC_HELP, SRC_VAL, SRC_PHEAD, SRC_PHI, SRC_PLO,
    SRC_COMMA, SRC_CR, SRC_LF
  } src_t;

  typedef struct packed {
    logic       push;
    src_t       src;
    err_t       err;
    logic [2:0] help;
    logic [4:0] idx;
    logic       line_wr;
    logic       line_clear;
    logic       pop;
    logic       tx_take;
    logic       res_load;
    logic       wr_period;
    logic       pat_wr;
    logic       pat_rd;
    logic [2:0] grp;
    logic [5:0] fit_len;
  } scp_cmd_t;

  typedef struct packed {
    logic in_pop;
    logic in_cr;
    logic fifo_empty;
    logic line_ge2;
    logic mode_ok;
    logic mode_rd;
    op_t  op;
    logic col2;
    logic col4;
    logic hex4_ok;
    logic hex2_ok;
    logic range4_ok;
    logic sim_ok;
    logic slot_ok;
    logic grp_comma;
    logic grp_hex_ok;
    logic fit;
  } scp_stat_t;

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) d = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) d = {1'b0, 4'(c - 8'h57)};
    return d;
  endfunction

  function automatic logic [5:0] err_len(err_t e);
    logic [5:0] n;
    unique case (e)
      ERR_MODE:    n = 6'd8;
      ERR_COMMAND: n = 6'd11;
      ERR_DELIM:   n = 6'd13;
      default:     n = 6'd9;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] err_byte(err_t e, logic [4:0] i);
    logic [71:0] w;
    logic [4:0]  n;
    logic [4:0]  k;
    logic [7:0]  b;
    unique case (e)
      ERR_MODE:    begin w = "mode";      n = 5'd4; end
      ERR_COMMAND: begin w = "command";   n = 5'd7; end
      ERR_DELIM:   begin w = "delimiter"; n = 5'd9; end
      ERR_VALUE:   begin w = "value";     n = 5'd5; end
      ERR_LIMIT:   begin w = "limit";     n = 5'd5; end
      ERR_INDEX:   begin w = "index";     n = 5'd5; end
      ERR_COMMA:   begin w = "comma";     n = 5'd5; end
      default:     begin w = '0;          n = 5'd0; end
    endcase
    k = i - 5'd2;
    if (i == 5'd0) b = CH_E;
    else if (i == 5'd1) b = CH_COLON;
    else if (k < n) b = w[8*(n-5'd1-k) +: 8];
    else if (k == n) b = CH_CR;
    else b = CH_LF;
    return b;
  endfunction

  function automatic logic [5:0] help_len(logic [2:0] h);
    logic [5:0] n;
    case (h)
      3'd0, 3'd1: n = 6'd22;
      3'd2:       n = 6'd25;
      3'd3:       n = 6'd27;
      default:    n = 6'd17;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] help_byte(logic [2:0] h, logic [4:0] i);
    logic [215:0] w;
    logic [4:0]   n;
    case (h)
      3'd0:    begin w = "HW: FR/FW-flash period";      n = 5'd22; end
      3'd1:    begin w = "HW: BR/BW-blank period";      n = 5'd22; end
      3'd2:    begin w = "HW: IR/IW-interval period";   n = 5'd25; end
      3'd3:    begin w = "HW: SR/SW-simulation period"; n = 5'd27; end
      default: begin w = "HW: PR/PW-pattern";           n = 5'd17; end
    endcase
    return (i < n) ? w[8*(n-5'd1-i) +: 8] : 8'h00;
  endfunction

endpackage

`default_nettype wire

@@ rtl/scp_in_if.sv @@
`default_nettype none

interface scp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/scp_out_if.sv @@
`default_nettype none

interface scp_out_if #(
  parameter int COUNT_W = 9
);
  logic               valid;
  logic               ready;
  logic [7:0]         tx_byte;
  logic               tx_valid;
  logic [COUNT_W-1:0] pending_count;
  logic [13:0]        flash_period_now;
  logic [13:0]        blank_period_now;
  logic [13:0]        interval_period_now;
  logic [7:0]         sim_period_now;

  modport source (output valid, tx_byte, tx_valid, pending_count, flash_period_now,
                  blank_period_now, interval_period_now, sim_period_now,
                  input ready);
  modport sink (input valid, tx_byte, tx_valid, pending_count, flash_period_now,
                blank_period_now, interval_period_now, sim_period_now,
                output ready);
endinterface

`default_nettype wire

@@ rtl/scp_ram.sv @@
`default_nettype none

module scp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/scp_datapath.sv @@
`default_nettype none
`include "serial_command_line_parser_defines.svh"

module scp_datapath import scp_pkg::*; #(
  parameter int LINE_BYTES     = 32,
  parameter int OUT_FIFO_DEPTH = 256,
  parameter int PATTERN_BYTES  = 5,
  parameter int PATTERN_SLOTS  = 16,
  localparam int FILL_W = $clog2(OUT_FIFO_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scp_cmd_t          cmd,
  output      scp_stat_t         stat,
  input  wire logic              in_action,
  input  wire logic [7:0]        in_rx_byte,
  output      logic [7:0]        res_tx,
  output      logic              res_txv,
  output      logic [FILL_W-1:0] res_pend,
  output      logic [13:0]       res_flash,
  output      logic [13:0]       res_blank,
  output      logic [13:0]       res_interval,
  output      logic [7:0]        res_sim
);

  localparam int LAW    = $clog2(LINE_BYTES);
  localparam int LFW    = $clog2(LINE_BYTES + 1);
  localparam int FAW    = $clog2(OUT_FIFO_DEPTH);
  localparam int PN     = PATTERN_SLOTS * PATTERN_BYTES;
  localparam int PAW    = (PN > 1) ? $clog2(PN) : 1;

  logic [7:0]        line_store [LINE_BYTES];
  logic [LFW-1:0]    line_fill;
  logic [FAW-1:0]    rd_ptr;
  logic [FAW-1:0]    wr_ptr;
  logic [FILL_W-1:0] out_fill;
  logic [13:0]       flash_period;
  logic [13:0]       blank_period;
  logic [13:0]       interval_period;
  logic [7:0]        sim_period;
  logic [PN-1:0]     pat_valid;
  logic              pat_valid_q;
  logic [7:0]        fifo_rdata;
  logic [7:0]        pat_rdata;
  logic [7:0]        pat_byte;
  logic [7:0]        push_byte;
  logic              push_ok;
  logic [PAW-1:0]    pat_addr;
  logic [7:0]        l0, l1, l2, l3, l4;
  logic [7:0]        lc;
  logic [4:0]        d3, d4, d5, d6, dslot;
  logic [15:0]       v4;
  logic [7:0]        v2;
  logic [6:0]        pos;
  logic [4:0]        gh, gl;
  logic [15:0]       cur_val;
  op_t               op_dec;

  function automatic logic [7:0] line_at(logic [6:0] k);
    logic [7:0] b;
    b = 8'h00;
    if (32'(k) < LINE_BYTES) b = line_store[k[LAW-1:0]];
    return b;
  endfunction

  always_comb begin
    l0 = line_at(7'd0);
    l1 = line_at(7'd1);
    l2 = line_at(7'd2);
    l3 = line_at(7'd3);
    l4 = line_at(7'd4);
    d3 = digit_of(l3);
    d4 = digit_of(l4);
    d5 = digit_of(line_at(7'd5));
    d6 = digit_of(line_at(7'd6));
    gh = digit_of(line_at(pos));
    gl = digit_of(line_at(pos + 7'd1));
    lc = line_at(pos + 7'd2);
  end

  assign dslot = d3;
  assign v4 = {d3[3:0], d4[3:0], d5[3:0], d6[3:0]};
  assign v2 = {d3[3:0], d4[3:0]};
  assign pos = 7'd5 + 7'd3 * 7'(cmd.grp);
  assign pat_addr = PAW'(32'(dslot[3:0]) * PATTERN_BYTES + 32'(cmd.grp));
  assign pat_byte = pat_valid_q ? pat_rdata : 8'h00;
  assign push_ok = cmd.push && (32'(out_fill) < OUT_FIFO_DEPTH);

  always_comb begin
    unique case (l0)
      CH_F:    op_dec = OP_FLASH;
      CH_B:    op_dec = OP_BLANK;
      CH_I:    op_dec = OP_INTERVAL;
      CH_S:    op_dec = OP_SIM;
      CH_P:    op_dec = OP_PATTERN;
      CH_H:    op_dec = OP_HELP;
      default: op_dec = OP_BAD;
    endcase
  end

  assign stat.op = op_dec;

  always_comb begin
    case (op_dec)
      OP_FLASH:    cur_val = {2'b00, flash_period};
      OP_BLANK:    cur_val = {2'b00, blank_period};
      OP_INTERVAL: cur_val = {2'b00, interval_period};
      default:     cur_val = {8'h00, sim_period};
    endcase
  end

  assign stat.in_pop     = in_action;
  assign stat.in_cr      = (in_rx_byte == CH_CR);
  assign stat.fifo_empty = (out_fill == '0);
  assign stat.line_ge2   = (line_fill >= LFW'(2));
  assign stat.mode_ok    = (l1 == CH_R) || (l1 == CH_W);
  assign stat.mode_rd    = (l1 == CH_R);
  assign stat.col2       = (l2 == CH_COLON);
  assign stat.col4       = (l4 == CH_COLON);
  assign stat.hex4_ok    = !d3[4] && !d4[4] && !d5[4] && !d6[4];
  assign stat.hex2_ok    = !d3[4] && !d4[4];
  assign stat.range4_ok  = (v4 >= PERIOD_MIN) && (v4 <= PERIOD_MAX);
  assign stat.sim_ok     = (v2 >= SIM_MIN);
  assign stat.slot_ok    = !dslot[4] && (32'(dslot[3:0]) < PATTERN_SLOTS);
  assign stat.grp_comma  = (lc == CH_COMMA);
  assign stat.grp_hex_ok = !gh[4] && !gl[4];
  assign stat.fit = (32'(out_fill) + 32'(cmd.fit_len)) <= OUT_FIFO_DEPTH;

  always_comb begin
    logic [4:0] nd;
    logic [4:0] k;
    logic [4:0] sh;
    nd = (op_dec == OP_SIM) ? 5'd2 : 5'd4;
    k  = cmd.idx - 5'd3;
    sh = nd - 5'd1 - k;
    case (cmd.src)
      SRC_RX:   push_byte = in_rx_byte;
      SRC_ERR:  push_byte = err_byte(cmd.err, cmd.idx);
      SRC_HELP: push_byte = help_byte(cmd.help, cmd.idx);
      SRC_VAL: begin
        if (cmd.idx == 5'd0) push_byte = l0;
        else if (cmd.idx == 5'd1) push_byte = CH_R;
        else if (cmd.idx == 5'd2) push_byte = CH_COLON;
        else if (k < nd) push_byte = hex_char(4'(cur_val >> {sh, 2'b00}));
        else if (k == nd) push_byte = CH_CR;
        else push_byte = CH_LF;
      end
      SRC_PHEAD: begin
        case (cmd.idx)
          5'd0:    push_byte = CH_P;
          5'd1:    push_byte = CH_R;
          5'd3:    push_byte = hex_char(dslot[3:0]);
          default: push_byte = CH_COLON;
        endcase
      end
      SRC_PHI:   push_byte = hex_char(pat_byte[7:4]);
      SRC_PLO:   push_byte = hex_char(pat_byte[3:0]);
      SRC_COMMA: push_byte = CH_COMMA;
      SRC_CR:    push_byte = CH_CR;
      SRC_LF:    push_byte = CH_LF;
      default:   push_byte = 8'h00;
    endcase
  end

  scp_ram #(.WIDTH(8), .DEPTH(OUT_FIFO_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (wr_ptr),
    .wdata (push_byte),
    .re    (cmd.pop),
    .raddr (rd_ptr),
    .rdata (fifo_rdata)
  );

  scp_ram #(.WIDTH(8), .DEPTH(PN)) u_pat_ram (
    .clk   (clk),
    .we    (cmd.pat_wr),
    .waddr (pat_addr),
    .wdata ({gh[3:0], gl[3:0]}),
    .re    (cmd.pat_rd),
    .raddr (pat_addr),
    .rdata (pat_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_BYTES; i++) line_store[i] <= 8'h00;
      line_fill       <= '0;
      rd_ptr          <= '0;
      wr_ptr          <= '0;
      out_fill        <= '0;
      flash_period    <= PERIOD_RESET;
      blank_period    <= PERIOD_RESET;
      interval_period <= PERIOD_RESET;
      sim_period      <= SIM_RESET;
      pat_valid       <= '0;
      pat_valid_q     <= 1'b0;
    end else begin
      if (cmd.line_wr && (32'(line_fill) < LINE_BYTES)) begin
        line_store[line_fill[LAW-1:0]] <= in_rx_byte;
        line_fill <= line_fill + LFW'(1);
      end
      if (cmd.line_clear) line_fill <= '0;
      if (push_ok) begin
        wr_ptr   <= (32'(wr_ptr) == OUT_FIFO_DEPTH - 1) ? '0 : wr_ptr + FAW'(1);
        out_fill <= out_fill + FILL_W'(1);
      end
      if (cmd.pop) begin
        rd_ptr   <= (32'(rd_ptr) == OUT_FIFO_DEPTH - 1) ? '0 : rd_ptr + FAW'(1);
        out_fill <= out_fill - FILL_W'(1);
      end
      if (cmd.wr_period) begin
        case (op_dec)
          OP_FLASH:    flash_period    <= v4[13:0];
          OP_BLANK:    blank_period    <= v4[13:0];
          OP_INTERVAL: interval_period <= v4[13:0];
          default:     sim_period      <= v2;
        endcase
      end
      if (cmd.pat_wr) pat_valid[pat_addr] <= 1'b1;
      if (cmd.pat_rd) pat_valid_q <= pat_valid[pat_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_tx       <= cmd.tx_take ? fifo_rdata : 8'h00;
      res_txv      <= cmd.tx_take;
      res_pend     <= out_fill;
      res_flash    <= flash_period;
      res_blank    <= blank_period;
      res_interval <= interval_period;
      res_sim      <= sim_period;
    end
  end

  `SCP_ASSERT(a_fill_bound, 32'(out_fill) <= OUT_FIFO_DEPTH)
  `SCP_ASSERT(a_no_push_pop, !(cmd.push && cmd.pop))
  `SCP_ASSERT(a_pop_nonempty, cmd.pop |-> out_fill != '0)

endmodule

`default_nettype wire

@@ rtl/scp_controller.sv @@
`default_nettype none

module scp_controller import scp_pkg::*; #(
  parameter int PATTERN_BYTES = 5
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  output      logic      out_valid,
  input  wire logic      out_ready,
  input  wire scp_stat_t stat,
  output      scp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_POP_WAIT, S_EOL, S_PW_GRP, S_MSG_FIT, S_MSG_EMIT,
    S_HELP_FIT, S_HELP_TXT, S_HELP_CR, S_HELP_LF,
    S_PAT_FIT, S_PAT_HEAD, S_PAT_FETCH, S_PAT_HI, S_PAT_LO, S_PAT_COMMA,
    S_PAT_CR, S_PAT_LF, S_FINISH, S_DONE
  } state_t;

  localparam logic [2:0] GRP_LAST = 3'(PATTERN_BYTES - 1);
  localparam logic [5:0] PAT_LEN  = 6'(7 + 3 * PATTERN_BYTES);

  state_t     state, state_next;
  logic       out_busy, out_busy_next;
  logic       took, took_next;
  src_t       msg_src, msg_src_next;
  err_t       err, err_next;
  logic [5:0] msg_len, msg_len_next;
  logic [4:0] idx, idx_next;
  logic [2:0] help, help_next;
  logic [2:0] grp, grp_next;

  assign out_valid = out_busy;

  always_comb begin
    logic start_err;
    logic start_val;
    err_t err_code;
    start_err     = 1'b0;
    start_val     = 1'b0;
    err_code      = ERR_MODE;
    state_next    = state;
    took_next     = took;
    msg_src_next  = msg_src;
    err_next      = err;
    msg_len_next  = msg_len;
    idx_next      = idx;
    help_next     = help;
    grp_next      = grp;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.src       = SRC_RX;
    cmd.err       = err;
    cmd.help      = help;
    cmd.idx       = idx;
    cmd.grp       = grp;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat.in_pop) begin
            took_next = !stat.fifo_empty;
            cmd.pop   = !stat.fifo_empty;
            state_next = stat.fifo_empty ? S_DONE : S_POP_WAIT;
          end else begin
            took_next   = 1'b0;
            cmd.push    = 1'b1;
            cmd.line_wr = 1'b1;
            state_next  = stat.in_cr ? S_EOL : S_DONE;
          end
        end
      end
      S_POP_WAIT: state_next = S_DONE;
      S_EOL: begin
        if (!stat.line_ge2) begin
          state_next = S_FINISH;
        end else if (!stat.mode_ok) begin
          start_err = 1'b1;
          err_code  = ERR_MODE;
        end else begin
          unique case (stat.op)
            OP_HELP: begin
              help_next  = 3'd0;
              state_next = S_HELP_FIT;
            end
            OP_FLASH, OP_BLANK, OP_INTERVAL: begin
              if (stat.mode_rd) start_val = 1'b1;
              else if (!stat.col2) begin start_err = 1'b1; err_code = ERR_DELIM; end
              else if (!stat.hex4_ok) begin start_err = 1'b1; err_code = ERR_VALUE; end
              else if (!stat.range4_ok) begin start_err = 1'b1; err_code = ERR_LIMIT; end
              else begin
                cmd.wr_period = 1'b1;
                start_val     = 1'b1;
              end
            end
            OP_SIM: begin
              if (stat.mode_rd) start_val = 1'b1;
              else if (!stat.col2) begin start_err = 1'b1; err_code = ERR_DELIM; end
              else if (!stat.hex2_ok) begin start_err = 1'b1; err_code = ERR_VALUE; end
              else if (!stat.sim_ok) begin start_err = 1'b1; err_code = ERR_LIMIT; end
              else begin
                cmd.wr_period = 1'b1;
                start_val     = 1'b1;
              end
            end
            OP_PATTERN: begin
              if (!stat.col2 || (!stat.mode_rd && !stat.col4)) begin
                start_err = 1'b1;
                err_code  = ERR_DELIM;
              end else if (!stat.slot_ok) begin
                start_err = 1'b1;
                err_code  = ERR_INDEX;
              end else if (stat.mode_rd) begin
                state_next = S_PAT_FIT;
              end else begin
                grp_next   = 3'd0;
                state_next = S_PW_GRP;
              end
            end
            default: begin
              start_err = 1'b1;
              err_code  = ERR_COMMAND;
            end
          endcase
        end
      end
      S_PW_GRP: begin
        if (!stat.grp_comma) begin
          start_err = 1'b1;
          err_code  = ERR_COMMA;
        end else if (!stat.grp_hex_ok) begin
          start_err = 1'b1;
          err_code  = ERR_VALUE;
        end else begin
          cmd.pat_wr = 1'b1;
          if (grp == GRP_LAST) state_next = S_PAT_FIT;
          else grp_next = grp + 3'd1;
        end
      end
      S_MSG_FIT: begin
        cmd.fit_len = msg_len;
        state_next  = stat.fit ? S_MSG_EMIT : S_FINISH;
      end
      S_MSG_EMIT: begin
        cmd.push = 1'b1;
        cmd.src  = msg_src;
        idx_next = idx + 5'd1;
        if ({1'b0, idx} == msg_len - 6'd1) state_next = S_FINISH;
      end
      S_HELP_FIT: begin
        cmd.fit_len = help_len(help);
        idx_next    = 5'd0;
        state_next  = stat.fit ? S_HELP_TXT : S_HELP_CR;
      end
      S_HELP_TXT: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_HELP;
        idx_next = idx + 5'd1;
        if ({1'b0, idx} == help_len(help) - 6'd1) state_next = S_HELP_CR;
      end
      S_HELP_CR: begin
        cmd.push   = 1'b1;
        cmd.src    = SRC_CR;
        state_next = S_HELP_LF;
      end
      S_HELP_LF: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_LF;
        if (help == HELP_LAST) state_next = S_FINISH;
        else begin
          help_next  = help + 3'd1;
          state_next = S_HELP_FIT;
        end
      end
      S_PAT_FIT: begin
        cmd.fit_len = PAT_LEN;
        idx_next    = 5'd0;
        state_next  = stat.fit ? S_PAT_HEAD : S_FINISH;
      end
      S_PAT_HEAD: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_PHEAD;
        idx_next = idx + 5'd1;
        if (idx == 5'd4) begin
          grp_next   = 3'd0;
          state_next = S_PAT_FETCH;
        end
      end
      S_PAT_FETCH: begin
        cmd.pat_rd = 1'b1;
        state_next = S_PAT_HI;
      end
      S_PAT_HI: begin
        cmd.push   = 1'b1;
        cmd.src    = SRC_PHI;
        state_next = S_PAT_LO;
      end
      S_PAT_LO: begin
        cmd.push   = 1'b1;
        cmd.src    = SRC_PLO;
        state_next = S_PAT_COMMA;
      end
      S_PAT_COMMA: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_COMMA;
        if (grp == GRP_LAST) state_next = S_PAT_CR;
        else begin
          grp_next   = grp + 3'd1;
          state_next = S_PAT_FETCH;
        end
      end
      S_PAT_CR: begin
        cmd.push   = 1'b1;
        cmd.src    = SRC_CR;
        state_next = S_PAT_LF;
      end
      S_PAT_LF: begin
        cmd.push   = 1'b1;
        cmd.src    = SRC_LF;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.line_clear = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!out_busy || out_ready) begin
          cmd.res_load = 1'b1;
          cmd.tx_take  = took;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (start_err) begin
      msg_src_next = SRC_ERR;
      err_next     = err_code;
      msg_len_next = err_len(err_code);
      idx_next     = 5'd0;
      state_next   = S_MSG_FIT;
    end else if (start_val) begin
      msg_src_next = SRC_VAL;
      msg_len_next = (stat.op == OP_SIM) ? 6'd7 : 6'd9;
      idx_next     = 5'd0;
      state_next   = S_MSG_FIT;
    end

    if (cmd.res_load) out_busy_next = 1'b1;
    else if (out_ready) out_busy_next = 1'b0;
    else out_busy_next = out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_busy <= 1'b0;
      took     <= 1'b0;
      msg_src  <= SRC_ERR;
      err      <= ERR_MODE;
      msg_len  <= '0;
      idx      <= '0;
      help     <= '0;
      grp      <= '0;
    end else begin
      state    <= state_next;
      out_busy <= out_busy_next;
      took     <= took_next;
      msg_src  <= msg_src_next;
      err      <= err_next;
      msg_len  <= msg_len_next;
      idx      <= idx_next;
      help     <= help_next;
      grp      <= grp_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/serial_command_line_parser.sv @@
// Channel  Dir  Payload                                         Handshake
// in_ch    in   action, rx_byte                                 valid/ready
// out_ch   out  tx_byte, tx_valid, pending_count, flash/blank/  valid/ready
//               interval/sim period readouts
//
// One item at a time. A pop goes through S_POP_WAIT unless the FIFO is
// empty, and a plain received byte goes straight to S_DONE. A carriage
// return pushes each reply byte, plus a pattern RAM fetch per group.
// The finished result waits in an output register, so the next item is taken
// while it is still unread; a full output register stalls only the S_DONE state.
// Synchronous reset clears the FIFO counts, line buffer, pattern valid bits
// and the controller, and returns the settings to their reset values.
`default_nettype none

module serial_command_line_parser import scp_pkg::*; #(
  parameter int LINE_BYTES     = 32,
  parameter int OUT_FIFO_DEPTH = 256,
  parameter int PATTERN_BYTES  = 5,
  parameter int PATTERN_SLOTS  = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  scp_in_if.sink    in_ch,
  scp_out_if.source out_ch
);

  scp_cmd_t  cmd;
  scp_stat_t stat;

  scp_controller #(.PATTERN_BYTES(PATTERN_BYTES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  scp_datapath #(
    .LINE_BYTES     (LINE_BYTES),
    .OUT_FIFO_DEPTH (OUT_FIFO_DEPTH),
    .PATTERN_BYTES  (PATTERN_BYTES),
    .PATTERN_SLOTS  (PATTERN_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_action    (in_ch.action),
    .in_rx_byte   (in_ch.rx_byte),
    .res_tx       (out_ch.tx_byte),
    .res_txv      (out_ch.tx_valid),
    .res_pend     (out_ch.pending_count),
    .res_flash    (out_ch.flash_period_now),
    .res_blank    (out_ch.blank_period_now),
    .res_interval (out_ch.interval_period_now),
    .res_sim      (out_ch.sim_period_now)
  );

endmodule

`default_nettype wire

@@ tb/scp_checker.sv @@
`default_nettype none

module scp_checker import scp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  scp_in_if         in_ch,
  scp_out_if        out_ch,
  output int        errors,
  output int        waiting,
  output int        fifo_level
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [8:0]  pending;
    logic [13:0] flash;
    logic [13:0] blank;
    logic [13:0] interval;
    logic [7:0]  sim;
  } reply_t;

  reply_t      replies_due[$];
  logic [7:0]  line_buf[32];
  int          line_len;
  logic [7:0]  tx_queue[$];
  logic [13:0] flash_p, blank_p, interval_p;
  logic [7:0]  sim_p;
  logic [7:0]  pattern_mem[80];

  initial begin
    waiting    = 0;
    fifo_level = 0;
  end

  function automatic int room();
    return 256 - tx_queue.size();
  endfunction

  function automatic void put(logic [7:0] b);
    if (tx_queue.size() < 256) tx_queue.push_back(b);
  endfunction

  function automatic void put_text(string s);
    foreach (s[i]) put(s[i]);
  endfunction

  function automatic logic [7:0] hex_ch(int n);
    return (n < 10) ? 8'(8'h30 + n) : 8'(8'h37 + n);
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - 8'h30;
    if (c >= "A" && c <= "F") return c - 8'h37;
    if (c >= "a" && c <= "f") return c - 8'h57;
    return -1;
  endfunction

  function automatic logic [7:0] at(int k);
    return (k < 32) ? line_buf[k] : 8'h00;
  endfunction

  function automatic void report_err(string w);
    if (room() < w.len() + 4) return;
    put_text({"E:", w});
    put(CH_CR);
    put(CH_LF);
  endfunction

  function automatic void readback(logic [7:0] cmd, int v, int digits);
    if (room() < digits + 5) return;
    put(cmd);
    put(CH_R);
    put(CH_COLON);
    for (int i = digits; i > 0; i--) put(hex_ch((v >> (4 * (i - 1))) & 15));
    put(CH_CR);
    put(CH_LF);
  endfunction

  function automatic bit parse_hex(int digits, output int v);
    int d;
    bit ok;
    ok = 1;
    v = 0;
    for (int i = 0; i < digits; i++) begin
      d = hex_val(at(3 + i));
      if (d < 0) ok = 0;
      v = (v << 4) | (d & 15);
    end
    return ok;
  endfunction

  function automatic void do_period(logic [7:0] cmd, bit rd, ref logic [13:0] p);
    int v;
    if (!rd) begin
      if (at(2) != CH_COLON) begin report_err("delimiter"); return; end
      if (!parse_hex(4, v)) begin report_err("value"); return; end
      if (v < 10 || v > 10000) begin report_err("limit"); return; end
      p = 14'(v);
    end
    readback(cmd, p, 4);
  endfunction

  function automatic void do_sim(bit rd);
    int v;
    if (!rd) begin
      if (at(2) != CH_COLON) begin report_err("delimiter"); return; end
      if (!parse_hex(2, v)) begin report_err("value"); return; end
      if (v < 50) begin report_err("limit"); return; end
      sim_p = 8'(v);
    end
    readback(CH_S, sim_p, 2);
  endfunction

  function automatic void show_row();
    int slot;
    logic [7:0] b;
    if (at(2) != CH_COLON) begin report_err("delimiter"); return; end
    slot = hex_val(at(3));
    if (slot < 0) begin report_err("index"); return; end
    if (room() < 22) return;
    put(CH_P);
    put(CH_R);
    put(CH_COLON);
    put(hex_ch(slot));
    put(CH_COLON);
    for (int i = 0; i < 5; i++) begin
      b = pattern_mem[slot * 5 + i];
      put(hex_ch(b[7:4]));
      put(hex_ch(b[3:0]));
      put(CH_COMMA);
    end
    put(CH_CR);
    put(CH_LF);
  endfunction

  function automatic void store_row();
    int slot, hi, lo, pos;
    if (at(2) != CH_COLON || at(4) != CH_COLON) begin report_err("delimiter"); return; end
    slot = hex_val(at(3));
    if (slot < 0) begin report_err("index"); return; end
    for (int i = 0; i < 5; i++) begin
      pos = 5 + 3 * i;
      hi = hex_val(at(pos));
      lo = hex_val(at(pos + 1));
      if (at(pos + 2) != CH_COMMA) begin report_err("comma"); return; end
      if (hi < 0 || lo < 0) begin report_err("value"); return; end
      pattern_mem[slot * 5 + i] = 8'((hi << 4) | lo);
    end
    show_row();
  endfunction

  function automatic void show_help();
    string txt[5];
    txt = '{"HW: FR/FW-flash period", "HW: BR/BW-blank period",
            "HW: IR/IW-interval period", "HW: SR/SW-simulation period",
            "HW: PR/PW-pattern"};
    foreach (txt[i]) begin
      if (room() >= txt[i].len()) put_text(txt[i]);
      put(CH_CR);
      put(CH_LF);
    end
  endfunction

  function automatic void decode_line();
    bit rd;
    if (line_buf[1] == CH_R) rd = 1;
    else if (line_buf[1] == CH_W) rd = 0;
    else begin report_err("mode"); return; end
    case (line_buf[0])
      CH_H: show_help();
      CH_F: do_period(CH_F, rd, flash_p);
      CH_B: do_period(CH_B, rd, blank_p);
      CH_I: do_period(CH_I, rd, interval_p);
      CH_S: do_sim(rd);
      CH_P: if (rd) show_row(); else store_row();
      default: report_err("command");
    endcase
  endfunction

  function automatic reply_t take_item(logic act, logic [7:0] c);
    reply_t r;
    r.tx_byte = 8'h00;
    r.tx_valid = 1'b0;
    if (!act) begin
      put(c);
      if (line_len < 32) begin
        line_buf[line_len] = c;
        line_len++;
      end
      if (c == CH_CR) begin
        if (line_len >= 2) decode_line();
        line_len = 0;
      end
    end else if (tx_queue.size() > 0) begin
      r.tx_byte = tx_queue.pop_front();
      r.tx_valid = 1'b1;
    end
    r.pending = 9'(tx_queue.size());
    r.flash = flash_p;
    r.blank = blank_p;
    r.interval = interval_p;
    r.sim = sim_p;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t e;
    if (rst) begin
      errors <= 0;
      replies_due.delete();
      tx_queue.delete();
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      foreach (pattern_mem[i]) pattern_mem[i] = 8'h00;
      line_len = 0;
      flash_p = PERIOD_RESET;
      blank_p = PERIOD_RESET;
      interval_p = PERIOD_RESET;
      sim_p = SIM_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected item tx_byte=%h", $time, out_ch.tx_byte);
          errors <= errors + 1;
        end else begin
          e = replies_due.pop_front();
          if (e.tx_byte !== out_ch.tx_byte || e.tx_valid !== out_ch.tx_valid ||
              e.pending !== out_ch.pending_count || e.flash !== out_ch.flash_period_now ||
              e.blank !== out_ch.blank_period_now ||
              e.interval !== out_ch.interval_period_now ||
              e.sim !== out_ch.sim_period_now) begin
            $display("%0t: mismatch expected byte=%h v=%b n=%0d f=%0d b=%0d i=%0d s=%0d",
                     $time, e.tx_byte, e.tx_valid, e.pending, e.flash, e.blank,
                     e.interval, e.sim);
            $display("%0t:            actual byte=%h v=%b n=%0d f=%0d b=%0d i=%0d s=%0d",
                     $time, out_ch.tx_byte, out_ch.tx_valid, out_ch.pending_count,
                     out_ch.flash_period_now, out_ch.blank_period_now,
                     out_ch.interval_period_now, out_ch.sim_period_now);
            errors <= errors + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        replies_due.push_back(take_item(in_ch.action, in_ch.rx_byte));
    end
    waiting    = replies_due.size();
    fifo_level = tx_queue.size();
  end
endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top import scp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, waiting, fifo_level;
  int   burst_left = 0;
  int   sent = 0;
  int   stall_mode = 0;
  int   stall_cnt = 0;
  logic [7:0] line_q[$];

  scp_in_if  in_ch();
  scp_out_if #(.COUNT_W(9)) out_ch();

  serial_command_line_parser dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  scp_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .waiting(waiting), .fifo_level(fifo_level)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      stall_cnt++;
      if (stall_cnt % 300 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 3) != 0);
        default: out_ch.ready = ((stall_cnt % 7) < 2);
      endcase
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic act, logic [7:0] c);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.rx_byte = c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_line(int pop_pct);
    foreach (line_q[i]) begin
      while ($urandom_range(0, 99) < pop_pct) send_item(1'b1, 8'($urandom));
      send_item(1'b0, line_q[i]);
    end
    line_q.delete();
  endtask

  task automatic send_text(string s);
    foreach (s[i]) line_q.push_back(s[i]);
    line_q.push_back(CH_CR);
    send_line(0);
  endtask

  task automatic drain();
    while (fifo_level > 0) send_item(1'b1, 8'($urandom));
  endtask

  function automatic void add_hex(int v, int digits);
    logic [7:0] c;
    for (int i = digits; i > 0; i--) begin
      c = 8'(((v >> (4 * (i - 1))) & 15) < 10 ? 8'h30 + ((v >> (4 * (i - 1))) & 15)
                                               : 8'h37 + ((v >> (4 * (i - 1))) & 15));
      if (c >= "A" && $urandom_range(0, 1)) c = c + 8'h20;
      line_q.push_back(c);
    end
  endfunction

  function automatic void build_line();
    int r;
    logic [7:0] cmds[4];
    cmds = '{CH_F, CH_B, CH_I, CH_S};
    r = $urandom_range(0, 99);
    if (r < 30) begin
      line_q.push_back(cmds[$urandom_range(0, 2)]);
      line_q.push_back(CH_W);
      line_q.push_back(CH_COLON);
      add_hex($urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
                                        : $urandom_range(10, 10000), 4);
    end else if (r < 42) begin
      line_q.push_back(CH_S);
      line_q.push_back(CH_W);
      line_q.push_back(CH_COLON);
      add_hex($urandom_range(0, 255), 2);
    end else if (r < 55) begin
      line_q.push_back(cmds[$urandom_range(0, 3)]);
      line_q.push_back(CH_R);
    end else if (r < 75) begin
      line_q.push_back(CH_P);
      line_q.push_back(CH_W);
      line_q.push_back(CH_COLON);
      add_hex($urandom_range(0, 15), 1);
      line_q.push_back(CH_COLON);
      for (int i = 0; i < 5; i++) begin
        add_hex($urandom_range(0, 255), 2);
        line_q.push_back(CH_COMMA);
      end
    end else if (r < 85) begin
      line_q.push_back(CH_P);
      line_q.push_back(CH_R);
      line_q.push_back(CH_COLON);
      add_hex($urandom_range(0, 15), 1);
    end else if (r < 88) begin
      line_q.push_back(CH_H);
      line_q.push_back($urandom_range(0, 1) ? CH_R : CH_W);
    end else begin
      repeat ($urandom_range(0, 40)) line_q.push_back(8'($urandom));
    end
    if (line_q.size() > 0 && $urandom_range(0, 9) == 0)
      line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom);
    line_q.push_back(CH_CR);
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.rx_byte = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(1'b1, 8'hFF);
    send_text("FW:2710");
    send_text("FW:000A");
    send_text("BW:0009");
    send_text("IW:2711");
    send_text("BW:00fF");
    send_text("IR");
    send_text("SW:32");
    send_text("SW:31");
    send_text("SW:FF");
    send_text("PW:F:00,FF,a5,5A,12,");
    send_text("PR:F");
    send_text("PR:G");
    send_text("PW:1:00,11");
    send_text("PW:2:0G,11,22,33,44,");
    send_text("XR");
    send_text("FX");
    send_text("F");
    send_text("FW2710");
    drain();
    send_text("HR");
    send_text("IW:0100 and a long tail past the line buffer end");
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h7F);
    send_item(1'b0, CH_CR);
    drain();
    // hold until every result is back
    in_ch.valid = 1'b0;
    while (waiting > 0) @(negedge clk);

    while (sent < 700) begin
      build_line();
      send_line($urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 50));
      if ($urandom_range(0, 2) != 0)
        repeat ($urandom_range(0, fifo_level)) send_item(1'b1, 8'($urandom));
    end
    drain();
    in_ch.valid = 1'b0;

    while (waiting > 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire
